// File: hdl/assert_macros.svh
// Assertion macros used by the step pulse generator controller.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset.
`define TSPG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define TSPG_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/tspg_pkg.sv
// Shared types and constants of the three-axis step pulse generator.
// Used by the divider, the datapath, the controller and the top level.
package tspg_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned PERIOD_W = 20;
  localparam int unsigned CD_W     = 21;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned MAX_AXES = 3;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd3;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd100;

  // Remainder unit retires one dividend bit per cycle.
  localparam int unsigned DIV_STEPS = PERIOD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_load;
    logic div_done;
  } dp_status_t;

endpackage

// File: hdl/tspg_divider.sv
// Bit-serial restoring remainder unit: step period modulo tick period.
// Depends on tspg_pkg for widths and the step count.
module tspg_divider
  import tspg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [PERIOD_W-1:0] dividend_i,
  input  logic [TICK_W-1:0]   divisor_i,
  output logic                busy_o,
  output logic [TICK_W-1:0]   rem_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PERIOD_W-1:0]  quo_q, quo_d;
  logic [TICK_W-1:0]    rem_q, rem_d;
  logic [TICK_W:0]      trial;
  logic [TICK_W:0]      diff;

  assign trial = {rem_q, quo_q[PERIOD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // restore unless the divisor fits
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      quo_d = {quo_q[PERIOD_W-2:0], 1'b0};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// File: hdl/tspg_datapath.sv
// Datapath: request latch, tick period register, per-axis state and result flags.
// Depends on tspg_pkg and instantiates tspg_divider.
module tspg_datapath
  import tspg_pkg::*;
#(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TICK_W-1:0]   cfg_data_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [AXIS_W-1:0]   axis_i,
  input  logic [COUNT_W-1:0]  step_count_i,
  input  logic [PERIOD_W-1:0] step_period_i,
  input  logic                direction_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output logic [MAX_AXES-1:0] step_o,
  output logic [TICK_W-1:0]   width_o [MAX_AXES],
  output logic [MAX_AXES-1:0] dir_o,
  output logic                running_o
);

  logic [TICK_W-1:0]   tick_q;
  logic [FUNC_W-1:0]   req_func_q;
  logic [AXIS_W-1:0]   req_axis_q;
  logic [COUNT_W-1:0]  req_count_q;
  logic [PERIOD_W-1:0] req_period_q;
  logic                req_dir_q;
  logic                run_q;

  logic [TICK_W-1:0]   div_rem;
  logic                div_busy;
  logic [TICK_W-1:0]   width_new;
  logic                tick_commit;

  logic [COUNT_W-1:0]  steps_left_q  [NUM_AXES];
  logic [CD_W-1:0]     countdown_q   [NUM_AXES];
  logic [PERIOD_W-1:0] period_q      [NUM_AXES];
  logic [TICK_W-1:0]   pulse_width_q [NUM_AXES];
  logic [NUM_AXES-1:0] dir_q;
  logic [NUM_AXES-1:0] step_q;
  logic [NUM_AXES-1:0] fire;
  logic [NUM_AXES-1:0] left_nz;

  tspg_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (step_period_i),
    .divisor_i  (tick_q),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  assign status_o.in_is_load = (func_i == FUNC_LOAD);
  assign status_o.div_done   = !div_busy;

  // A zero tick period gives a zero pulse width.
  assign width_new   = (tick_q == '0) ? '0 : div_rem;
  assign tick_commit = cmd_i.commit && (req_func_q == FUNC_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TICK_RESET;
    end else if (cfg_we_i) begin
      tick_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_func_q   <= func_i;
      req_axis_q   <= axis_i;
      req_count_q  <= step_count_i;
      req_period_q <= step_period_i;
      req_dir_q    <= direction_i;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic               load_hit;
    logic               active;
    logic [COUNT_W-1:0] left_after;

    assign load_hit = cmd_i.commit && (req_func_q == FUNC_LOAD)
                      && (req_axis_q == AXIS_W'(a));
    assign active   = run_q && (steps_left_q[a] != '0);
    assign fire[a]  = (req_func_q == FUNC_TICK) && active
                      && (countdown_q[a] < CD_W'(tick_q));
    assign left_after = fire[a] ? steps_left_q[a] - COUNT_W'(1) : steps_left_q[a];
    assign left_nz[a] = (left_after != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        steps_left_q[a]  <= '0;
        countdown_q[a]   <= '0;
        period_q[a]      <= '0;
        pulse_width_q[a] <= '0;
        dir_q[a]         <= 1'b0;
        step_q[a]        <= 1'b0;
      end else begin
        if (cmd_i.commit) begin
          step_q[a] <= fire[a];
        end
        if (load_hit) begin
          steps_left_q[a]  <= req_count_q;
          period_q[a]      <= req_period_q;
          pulse_width_q[a] <= width_new;
          countdown_q[a]   <= CD_W'(req_period_q) - CD_W'(width_new);
          dir_q[a]         <= req_dir_q;
        end else if (tick_commit && active) begin
          steps_left_q[a] <= left_after;
          // reload to period plus tick, less one tick, is the period itself
          countdown_q[a]  <= fire[a] ? CD_W'(period_q[a])
                                     : countdown_q[a] - CD_W'(tick_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (cmd_i.commit) begin
      unique case (req_func_q)
        FUNC_TICK:  run_q <= run_q && (|left_nz);
        FUNC_START: run_q <= 1'b1;
        FUNC_STOP:  run_q <= 1'b0;
        default:    run_q <= run_q;
      endcase
    end
  end

  for (genvar a = 0; a < MAX_AXES; a++) begin : g_out
    if (a < NUM_AXES) begin : g_live
      assign step_o[a]  = step_q[a];
      assign width_o[a] = step_q[a] ? pulse_width_q[a] : '0;
      assign dir_o[a]   = dir_q[a];
    end else begin : g_absent
      assign step_o[a]  = 1'b0;
      assign width_o[a] = '0;
      assign dir_o[a]   = 1'b0;
    end
  end

  assign running_o = run_q;

endmodule

// File: hdl/tspg_ctrl.sv
// Controller: request acceptance, remainder wait, commit and result handshake.
// Depends on tspg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspg_ctrl
  import tspg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture   = accept;
    cmd_o.div_start = accept && status_i.in_is_load;
    cmd_o.commit    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = status_i.in_is_load ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the new result
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `TSPG_ASSERT(a_accept_leaves_idle, accept |=> state_q != ST_IDLE, "accept stayed idle")
  `TSPG_ASSERT(a_div_start, cmd_o.div_start |=> !status_i.div_done, "divider not started")
  `TSPG_ASSERT(a_div_exec, state_q == ST_DIV && status_i.div_done |=> state_q == ST_EXEC, "no exec")
  `TSPG_ASSERT(a_commit_sets_valid, cmd_o.commit |=> out_valid_q, "no result after commit")
  `TSPG_ASSERT_NEVER(a_no_overwrite, cmd_o.commit && !slot_free, "result overwritten")

endmodule

// File: hdl/three_axis_step_pulse_generator.sv
// Top level of the three-axis step pulse generator.
// Depends on tspg_pkg, tspg_ctrl, tspg_datapath (with tspg_divider).
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   func_i axis_i step_count_i step_period_i direction_i
//   out      out_valid_o / out_ready_i step_*_o width_*_o dir_*_o running_o
//   cfg      cfg_we_i                  cfg_data_i (tick period)
//
// Tick, start and stop go from acceptance to the execute state, then commit; the
// result valid flag is registered. Loads first wait in the divide state for the pulse
// width from a bit-serial remainder unit, one of the 20 period bits per cycle.
// One request is in flight at a time; a new one is taken while the last
// result waits at the output. A stalled output holds the next commit.
// Reset clears all axis state and the run flag and sets the tick period to 100.
module three_axis_step_pulse_generator
  import tspg_pkg::*;
#(
  parameter int unsigned NUM_AXES = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TICK_W-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [AXIS_W-1:0]   axis_i,
  input  logic [COUNT_W-1:0]  step_count_i,
  input  logic [PERIOD_W-1:0] step_period_i,
  input  logic                direction_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                step_x_o,
  output logic                step_y_o,
  output logic                step_z_o,
  output logic [TICK_W-1:0]   width_x_o,
  output logic [TICK_W-1:0]   width_y_o,
  output logic [TICK_W-1:0]   width_z_o,
  output logic                dir_x_o,
  output logic                dir_y_o,
  output logic                dir_z_o,
  output logic                running_o
);

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic [MAX_AXES-1:0] step;
  logic [TICK_W-1:0]   width [MAX_AXES];
  logic [MAX_AXES-1:0] dir;

  tspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tspg_datapath #(
    .NUM_AXES (NUM_AXES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .axis_i        (axis_i),
    .step_count_i  (step_count_i),
    .step_period_i (step_period_i),
    .direction_i   (direction_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .step_o        (step),
    .width_o       (width),
    .dir_o         (dir),
    .running_o     (running_o)
  );

  assign step_x_o  = step[0];
  assign step_y_o  = step[1];
  assign step_z_o  = step[2];
  assign width_x_o = width[0];
  assign width_y_o = width[1];
  assign width_z_o = width[2];
  assign dir_x_o   = dir[0];
  assign dir_y_o   = dir[1];
  assign dir_z_o   = dir[2];

endmodule
